// File: src/x25519_scalar_multiply_assert.svh
// Assertion macros used by the X25519 scalar multiplier top level.
// Macros expect signals named clk and rst_n in the including module.
`ifndef X25519_SCALAR_MULTIPLY_ASSERT_SVH
`define X25519_SCALAR_MULTIPLY_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define X25_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("x25 assertion failed");

// Next-cycle implication, ignored while in reset.
`define X25_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("x25 assertion failed");

`endif

// File: src/x25_pkg.sv
// Shared types, constants and microcode for the X25519 scalar multiplier.
// No dependencies.
package x25_pkg;

    localparam int FE_W      = 256;
    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 4;
    localparam int LIMB_W    = 32;
    localparam int RED_W     = 263;
    localparam int ADDR_W    = 5;
    localparam int MEM_DEPTH = 32;

    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_POINT   = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    localparam logic [16:0] A24_VAL    = 17'd121666;
    localparam logic [7:0]  LADDER_TOP = 8'd254;
    // low bits of p-2 below bit 5
    localparam logic [7:0]  INV_LOW_BITS = 8'h0b;

    // Logical storage slots
    localparam logic [ADDR_W-1:0] SLOT_X1  = 5'd0;
    localparam logic [ADDR_W-1:0] SLOT_X2  = 5'd1;
    localparam logic [ADDR_W-1:0] SLOT_Z2  = 5'd2;
    localparam logic [ADDR_W-1:0] SLOT_X3  = 5'd3;
    localparam logic [ADDR_W-1:0] SLOT_Z3  = 5'd4;
    localparam logic [ADDR_W-1:0] SLOT_A24 = 5'd5;
    localparam logic [ADDR_W-1:0] SLOT_A   = 5'd6;
    localparam logic [ADDR_W-1:0] SLOT_AA  = 5'd7;
    localparam logic [ADDR_W-1:0] SLOT_B   = 5'd8;
    localparam logic [ADDR_W-1:0] SLOT_BB  = 5'd9;
    localparam logic [ADDR_W-1:0] SLOT_E   = 5'd10;
    localparam logic [ADDR_W-1:0] SLOT_C   = 5'd11;
    localparam logic [ADDR_W-1:0] SLOT_D   = 5'd12;
    localparam logic [ADDR_W-1:0] SLOT_DA  = 5'd13;
    localparam logic [ADDR_W-1:0] SLOT_CB  = 5'd14;
    localparam logic [ADDR_W-1:0] SLOT_T   = 5'd15;
    localparam logic [ADDR_W-1:0] SLOT_SC  = 5'd16;
    localparam logic [ADDR_W-1:0] SLOT_PT  = 5'd17;
    localparam logic [ADDR_W-1:0] SLOT_ACC = 5'd18;

    localparam logic [4:0] INIT_LAST   = 5'd6;
    localparam logic [4:0] LADDER_LAST = 5'd17;

    localparam logic [FE_W-1:0] LOW_ORDER_PTS [7] = '{
        256'h0,
        256'h1,
        256'h00b8495f16056286_fdb1329ceb8d09da_6ac49ff1fae35616_aeb8413b7c7aebe0,
        256'h57119fd0dd4e22d8_868e1c58c45c4404_5bef839c55b1d0b1_248c50a3bc959c5f,
        256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffec,
        256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffed,
        256'h7fffffffffffffff_ffffffffffffffff_ffffffffffffffff_ffffffffffffffee
    };

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_CANON,
        ALU_ONE,
        ALU_ZERO,
        ALU_A24,
        ALU_UCOORD
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] src_a;
        logic [ADDR_W-1:0] src_b;
    } uop_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
        logic    base;
    } alu_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KCAP,
        ST_PCAP,
        ST_RDA,
        ST_RDB,
        ST_GO,
        ST_ALU,
        ST_ORD,
        ST_OCAP,
        ST_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        PH_INIT,
        PH_LADDER,
        PH_INV,
        PH_FINAL
    } phase_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_MTAIL,
        AL_RED,
        AL_FOLD,
        AL_CANON,
        AL_DONE
    } alu_state_t;

    function automatic uop_t init_uop(input logic [4:0] idx);
        uop_t u;
        case (idx)
            5'd0:    u = '{ALU_UCOORD, SLOT_X1,  SLOT_PT, SLOT_PT};
            5'd1:    u = '{ALU_UCOORD, SLOT_X3,  SLOT_PT, SLOT_PT};
            5'd2:    u = '{ALU_ONE,    SLOT_X2,  SLOT_X2, SLOT_X2};
            5'd3:    u = '{ALU_ZERO,   SLOT_Z2,  SLOT_Z2, SLOT_Z2};
            5'd4:    u = '{ALU_ONE,    SLOT_Z3,  SLOT_Z3, SLOT_Z3};
            5'd5:    u = '{ALU_A24,    SLOT_A24, SLOT_A24, SLOT_A24};
            default: u = '{ALU_ONE,    SLOT_ACC, SLOT_ACC, SLOT_ACC};
        endcase
        return u;
    endfunction

    function automatic uop_t ladder_uop(input logic [4:0] idx);
        uop_t u;
        case (idx)
            5'd0:    u = '{ALU_ADD, SLOT_A,  SLOT_X2, SLOT_Z2};
            5'd1:    u = '{ALU_MUL, SLOT_AA, SLOT_A,  SLOT_A};
            5'd2:    u = '{ALU_SUB, SLOT_B,  SLOT_X2, SLOT_Z2};
            5'd3:    u = '{ALU_MUL, SLOT_BB, SLOT_B,  SLOT_B};
            5'd4:    u = '{ALU_SUB, SLOT_E,  SLOT_AA, SLOT_BB};
            5'd5:    u = '{ALU_ADD, SLOT_C,  SLOT_X3, SLOT_Z3};
            5'd6:    u = '{ALU_SUB, SLOT_D,  SLOT_X3, SLOT_Z3};
            5'd7:    u = '{ALU_MUL, SLOT_DA, SLOT_D,  SLOT_A};
            5'd8:    u = '{ALU_MUL, SLOT_CB, SLOT_C,  SLOT_B};
            5'd9:    u = '{ALU_ADD, SLOT_T,  SLOT_DA, SLOT_CB};
            5'd10:   u = '{ALU_MUL, SLOT_X3, SLOT_T,  SLOT_T};
            5'd11:   u = '{ALU_SUB, SLOT_T,  SLOT_DA, SLOT_CB};
            5'd12:   u = '{ALU_MUL, SLOT_T,  SLOT_T,  SLOT_T};
            5'd13:   u = '{ALU_MUL, SLOT_Z3, SLOT_X1, SLOT_T};
            5'd14:   u = '{ALU_MUL, SLOT_X2, SLOT_AA, SLOT_BB};
            5'd15:   u = '{ALU_MUL, SLOT_T,  SLOT_E,  SLOT_A24};
            5'd16:   u = '{ALU_ADD, SLOT_T,  SLOT_T,  SLOT_BB};
            default: u = '{ALU_MUL, SLOT_Z2, SLOT_E,  SLOT_T};
        endcase
        return u;
    endfunction

endpackage

// File: src/x25519_scalar_multiply.sv
// X25519 scalar multiplier top level: operand memory, microcode sequencer.
// Depends on x25_pkg, x25_alu and x25519_scalar_multiply_assert.svh.
//
// channel   dir  handshake              payload
// command   in   start & !busy          kind, word_index, word, use_base_point
// result    out  result_valid           result_word, result_index, last,
//                                       result_all_zero, low_order_input
//
// Loads are written straight into the store and leave busy low.
// A compute performs ~3060 field multiplies on the single 32x32 multiplier,
// with every operand read through the one read port.
// The four result words follow on consecutive cycles; busy drops with the fourth.
// Reset clears control only; stores hold nothing valid until loaded.
// The receiver cannot stall; results are never held back.
module x25519_scalar_multiply
    import x25_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        kind,
    input  logic [1:0]        word_index,
    input  logic [WORD_W-1:0] word,
    input  logic              use_base_point,
    output logic              result_valid,
    output logic [WORD_W-1:0] result_word,
    output logic [1:0]        result_index,
    output logic              last,
    output logic              result_all_zero,
    output logic              low_order_input
);

    `include "x25519_scalar_multiply_assert.svh"

    top_state_t        state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [4:0]        idx_reg, idx_next;
    logic [7:0]        step_reg, step_next;
    logic              inv_mul_reg, inv_mul_next;
    logic              swap_flag_reg, swap_flag_next;
    logic              base_reg, base_next;
    logic [1:0]        out_cnt_reg, out_cnt_next;
    logic              result_valid_reg, result_valid_next;
    logic              low_order_reg, low_order_next;
    logic              zero_reg, zero_next;
    logic [FE_W-1:0]   k_reg, k_next;
    logic [FE_W-1:0]   opa_reg, opa_next;
    logic [FE_W-1:0]   res_reg, res_next;
    logic [WORD_W-1:0] result_word_reg, result_word_next;
    logic [1:0]        result_index_reg, result_index_next;
    logic              last_reg, last_next;

    logic [FE_W-1:0]   fe_mem [MEM_DEPTH];
    logic [FE_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [3:0]        mem_wmask;
    logic [FE_W-1:0]   mem_wdata;

    alu_req_t          alu_req;
    logic              alu_done;
    logic [FE_W-1:0]   alu_result;

    uop_t              uop;
    logic              accept;
    logic              low_match;
    logic              inv_bit;

    // Ladder swap is done by renaming slots, not by moving data
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] s, input logic sw);
        logic [ADDR_W-1:0] p;
        p = s;
        if (sw)
        begin
            if (s == SLOT_X2)
                p = SLOT_X3;
            else if (s == SLOT_X3)
                p = SLOT_X2;
            else if (s == SLOT_Z2)
                p = SLOT_Z3;
            else if (s == SLOT_Z3)
                p = SLOT_Z2;
        end
        return p;
    endfunction

    x25_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .opa    (opa_reg),
        .opb    (rd_data_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign accept          = start && !busy;
    assign result_valid    = result_valid_reg;
    assign result_word     = result_word_reg;
    assign result_index    = result_index_reg;
    assign last            = last_reg;
    assign result_all_zero = zero_reg;
    assign low_order_input = low_order_reg;

    assign inv_bit = (step_reg >= 8'd5) || INV_LOW_BITS[step_reg[2:0]];

    always_comb
    begin
        low_match = 1'b0;
        for (int i = 0; i < 7; i++)
            if (rd_data_reg == LOW_ORDER_PTS[i])
                low_match = 1'b1;
    end

    always_comb
    begin
        case (phase_reg)
            PH_INIT:   uop = init_uop(idx_reg);
            PH_LADDER: uop = ladder_uop(idx_reg);
            PH_INV:    uop = inv_mul_reg ? uop_t'{ALU_MUL, SLOT_ACC, SLOT_ACC, SLOT_Z2}
                                         : uop_t'{ALU_MUL, SLOT_ACC, SLOT_ACC, SLOT_ACC};
            default:   uop = (idx_reg == 5'd0) ? uop_t'{ALU_MUL, SLOT_T, SLOT_X2, SLOT_ACC}
                                               : uop_t'{ALU_CANON, SLOT_T, SLOT_T, SLOT_T};
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        idx_next          = idx_reg;
        step_next         = step_reg;
        inv_mul_next      = inv_mul_reg;
        swap_flag_next    = swap_flag_reg;
        base_next         = base_reg;
        out_cnt_next      = out_cnt_reg;
        result_valid_next = 1'b0;
        low_order_next    = low_order_reg;
        zero_next         = zero_reg;
        k_next            = k_reg;
        opa_next          = opa_reg;
        res_next          = res_reg;
        result_word_next  = result_word_reg;
        result_index_next = result_index_reg;
        last_next         = last_reg;
        rd_addr           = SLOT_SC;
        mem_we            = 1'b0;
        mem_waddr         = phys(uop.dst, swap_flag_reg);
        mem_wmask         = 4'hf;
        mem_wdata         = alu_result;
        alu_req           = '{1'b0, uop.op, base_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_SCALAR || kind == KIND_POINT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = (kind == KIND_SCALAR) ? SLOT_SC : SLOT_PT;
                        mem_wmask = 4'b0001 << word_index;
                        mem_wdata = {NUM_WORDS{word}};
                    end
                    else if (kind == KIND_COMPUTE)
                    begin
                        base_next  = use_base_point;
                        state_next = ST_KCAP;
                    end
                end
            end
            ST_KCAP:
            begin
                // clamp the scalar
                k_next      = rd_data_reg;
                k_next[2:0] = 3'b000;
                k_next[255] = 1'b0;
                k_next[254] = 1'b1;
                rd_addr     = SLOT_PT;
                state_next  = ST_PCAP;
            end
            ST_PCAP:
            begin
                low_order_next = !base_reg && low_match;
                phase_next     = PH_INIT;
                idx_next       = 5'd0;
                swap_flag_next = 1'b0;
                state_next     = ST_RDA;
            end
            ST_RDA:
            begin
                rd_addr    = phys(uop.src_a, swap_flag_reg);
                state_next = ST_RDB;
            end
            ST_RDB:
            begin
                opa_next   = rd_data_reg;
                rd_addr    = phys(uop.src_b, swap_flag_reg);
                state_next = ST_GO;
            end
            ST_GO:
            begin
                alu_req.start = 1'b1;
                state_next    = ST_ALU;
            end
            ST_ALU:
            begin
                if (alu_done)
                begin
                    // write back; the next read is issued from ST_RDA
                    mem_we     = 1'b1;
                    state_next = ST_RDA;
                    case (phase_reg)
                        PH_INIT:
                        begin
                            if (idx_reg == INIT_LAST)
                            begin
                                phase_next     = PH_LADDER;
                                idx_next       = 5'd0;
                                step_next      = LADDER_TOP;
                                swap_flag_next = k_reg[LADDER_TOP];
                            end
                            else
                                idx_next = idx_reg + 5'd1;
                        end
                        PH_LADDER:
                        begin
                            if (idx_reg != LADDER_LAST)
                                idx_next = idx_reg + 5'd1;
                            else if (step_reg == 8'd0)
                            begin
                                phase_next     = PH_INV;
                                step_next      = LADDER_TOP;
                                inv_mul_next   = 1'b0;
                                swap_flag_next = 1'b0;
                                idx_next       = 5'd0;
                            end
                            else
                            begin
                                step_next      = step_reg - 8'd1;
                                idx_next       = 5'd0;
                                swap_flag_next = k_reg[step_reg - 8'd1];
                            end
                        end
                        PH_INV:
                        begin
                            if (!inv_mul_reg && inv_bit)
                                inv_mul_next = 1'b1;
                            else
                            begin
                                inv_mul_next = 1'b0;
                                if (step_reg == 8'd0)
                                begin
                                    phase_next = PH_FINAL;
                                    idx_next   = 5'd0;
                                end
                                else
                                    step_next = step_reg - 8'd1;
                            end
                        end
                        default:
                        begin
                            if (idx_reg == 5'd0)
                                idx_next = 5'd1;
                            else
                                state_next = ST_ORD;
                        end
                    endcase
                end
            end
            ST_ORD:
            begin
                rd_addr    = SLOT_T;
                state_next = ST_OCAP;
            end
            ST_OCAP:
            begin
                res_next     = rd_data_reg;
                zero_next    = (rd_data_reg == '0);
                out_cnt_next = 2'd0;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                result_valid_next = 1'b1;
                result_word_next  = res_reg[{out_cnt_reg, 6'b0} +: WORD_W];
                result_index_next = out_cnt_reg;
                last_next         = (out_cnt_reg == 2'd3);
                out_cnt_next      = out_cnt_reg + 2'd1;
                if (out_cnt_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_INIT;
            idx_reg          <= '0;
            step_reg         <= '0;
            inv_mul_reg      <= 1'b0;
            swap_flag_reg    <= 1'b0;
            base_reg         <= 1'b0;
            out_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
            low_order_reg    <= 1'b0;
            zero_reg         <= 1'b0;
            last_reg         <= 1'b0;
            result_index_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            idx_reg          <= idx_next;
            step_reg         <= step_next;
            inv_mul_reg      <= inv_mul_next;
            swap_flag_reg    <= swap_flag_next;
            base_reg         <= base_next;
            out_cnt_reg      <= out_cnt_next;
            result_valid_reg <= result_valid_next;
            low_order_reg    <= low_order_next;
            zero_reg         <= zero_next;
            last_reg         <= last_next;
            result_index_reg <= result_index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg           <= k_next;
        opa_reg         <= opa_next;
        res_reg         <= res_next;
        result_word_reg <= result_word_next;
    end

    // Operand memory: 64-bit lane write enables, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int l = 0; l < NUM_WORDS; l++)
                if (mem_wmask[l])
                    fe_mem[mem_waddr][l*WORD_W +: WORD_W] <= mem_wdata[l*WORD_W +: WORD_W];
        end
        rd_data_reg <= fe_mem[rd_addr];
    end

    `X25_ASSERT_NEXT(a_words_back_to_back, result_valid && !last, result_valid)
    `X25_ASSERT_IMP(a_last_is_top_word, result_valid && last, result_index == 2'd3)
    `X25_ASSERT_IMP(a_swap_only_in_ladder, swap_flag_reg, phase_reg == PH_LADDER)
    `X25_ASSERT_IMP(a_alu_done_when_waiting, alu_done, state_reg == ST_ALU)
    `X25_ASSERT_IMP(a_no_load_write_while_busy, mem_we && mem_wmask != 4'hf, !busy)

endmodule

// File: src/x25_alu.sv
// Field arithmetic unit mod 2^255-19: add, sub, multiply, canonical reduce, constant and u-coordinate loads.
// One 32x32 multiplier shared over 64 partial products. Depends on x25_pkg.
module x25_alu
    import x25_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  alu_req_t        req,
    input  logic [FE_W-1:0] opa,
    input  logic [FE_W-1:0] opb,
    output logic            done,
    output logic [FE_W-1:0] result
);

    localparam logic [RED_W-1:0] FOUR_P = (RED_W'(1) << 257) - RED_W'(76);

    alu_state_t          state_reg, state_next;
    alu_op_t             op_reg, op_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [1:0]          fcnt_reg, fcnt_next;
    logic                pvalid_reg, pvalid_next;
    logic [FE_W-1:0]     a_reg, a_next;
    logic [FE_W-1:0]     b_reg, b_next;
    logic [2*FE_W-1:0]   acc_reg, acc_next;
    logic [2*LIMB_W-1:0] prod_reg, prod_next;
    logic [3:0]          pos_reg, pos_next;
    logic [RED_W-1:0]    v_reg, v_next;

    logic [LIMB_W-1:0]   a_limb, b_limb;
    logic [2*FE_W-1:0]   prod_shifted;
    logic [FE_W-1:0]     canon_t;

    function automatic logic [RED_W-1:0] times38(input logic [RED_W-1:0] x);
        return (x << 5) + (x << 2) + (x << 1);
    endfunction

    assign a_limb       = a_reg[{cnt_reg[5:3], 5'b0} +: LIMB_W];
    assign b_limb       = b_reg[{cnt_reg[2:0], 5'b0} +: LIMB_W];
    assign prod_shifted = {{(2*FE_W-2*LIMB_W){1'b0}}, prod_reg} << {pos_reg, 5'b0};
    assign canon_t      = v_reg[FE_W-1:0] + FE_W'(19);

    assign done   = (state_reg == AL_DONE);
    assign result = v_reg[FE_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        fcnt_next   = fcnt_reg;
        pvalid_next = 1'b0;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        pos_next    = pos_reg;
        v_next      = v_reg;
        case (state_reg)
            AL_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    fcnt_next = 2'd0;
                    case (req.op)
                        ALU_ADD:
                        begin
                            v_next     = {7'b0, opa} + {7'b0, opb};
                            state_next = AL_FOLD;
                        end
                        ALU_SUB:
                        begin
                            v_next     = {7'b0, opa} + FOUR_P - {7'b0, opb};
                            state_next = AL_FOLD;
                        end
                        ALU_MUL:
                        begin
                            a_next     = opa;
                            b_next     = opb;
                            acc_next   = '0;
                            cnt_next   = 6'd0;
                            state_next = AL_MUL;
                        end
                        ALU_CANON:
                        begin
                            v_next     = {7'b0, opa};
                            state_next = AL_CANON;
                        end
                        ALU_ONE:
                        begin
                            v_next     = RED_W'(1);
                            state_next = AL_DONE;
                        end
                        ALU_ZERO:
                        begin
                            v_next     = '0;
                            state_next = AL_DONE;
                        end
                        ALU_A24:
                        begin
                            v_next     = RED_W'(A24_VAL);
                            state_next = AL_DONE;
                        end
                        default:
                        begin
                            // u-coordinate: top bit dropped, or the base point
                            v_next     = req.base ? RED_W'(9) : {8'b0, opa[FE_W-2:0]};
                            state_next = AL_DONE;
                        end
                    endcase
                end
            end
            AL_MUL:
            begin
                prod_next   = a_limb * b_limb;
                pos_next    = {1'b0, cnt_reg[5:3]} + {1'b0, cnt_reg[2:0]};
                pvalid_next = 1'b1;
                if (pvalid_reg)
                    acc_next = acc_reg + prod_shifted;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = AL_MTAIL;
            end
            AL_MTAIL:
            begin
                acc_next   = acc_reg + prod_shifted;
                state_next = AL_RED;
            end
            AL_RED:
            begin
                // 2^256 = 38 mod p
                v_next     = {7'b0, acc_reg[FE_W-1:0]} + times38({7'b0, acc_reg[2*FE_W-1:FE_W]});
                fcnt_next  = 2'd0;
                state_next = AL_FOLD;
            end
            AL_FOLD:
            begin
                v_next    = {7'b0, v_reg[FE_W-1:0]}
                          + times38({256'b0, v_reg[RED_W-1:FE_W]});
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd2)
                    state_next = AL_DONE;
            end
            AL_CANON:
            begin
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd2)
                begin
                    if (canon_t[FE_W-1])
                        v_next = {8'b0, canon_t[FE_W-2:0]};
                    state_next = AL_DONE;
                end
                else
                begin
                    v_next = {8'b0, v_reg[FE_W-2:0]}
                           + (v_reg[FE_W-1] ? RED_W'(19) : RED_W'(0));
                end
            end
            AL_DONE:
            begin
                state_next = AL_IDLE;
            end
            default:
            begin
                state_next = AL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= AL_IDLE;
            op_reg     <= ALU_ZERO;
            cnt_reg    <= '0;
            fcnt_reg   <= '0;
            pvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            cnt_reg    <= cnt_next;
            fcnt_reg   <= fcnt_next;
            pvalid_reg <= pvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        pos_reg  <= pos_next;
        v_reg    <= v_next;
    end

endmodule

// File: dv/tb_x25519_scalar_multiply.sv
// Self-checking testbench for the X25519 scalar multiplier (x25519_scalar_multiply).
// Depends on x25_pkg and the RTL; predicts each u-coordinate with 512-bit modular arithmetic.
`timescale 1ns / 1ps

module tb_x25519_scalar_multiply;
    import x25_pkg::*;

    localparam logic [255:0] P25519 = (256'd1 << 255) - 256'd19;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [1:0]        index;
        logic              last;
        logic              all_zero;
        logic              low_order;
    } ucoord_word_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        kind;
    logic [1:0]        word_index;
    logic [WORD_W-1:0] word;
    logic              use_base_point;
    logic              result_valid;
    logic [WORD_W-1:0] result_word;
    logic [1:0]        result_index;
    logic              last;
    logic              result_all_zero;
    logic              low_order_input;

    logic [WORD_W-1:0] scalar_words [4];
    logic [WORD_W-1:0] point_words [4];
    ucoord_word_t      expected_words [$];
    int                errors;

    x25519_scalar_multiply uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .word_index      (word_index),
        .word            (word),
        .use_base_point  (use_base_point),
        .result_valid    (result_valid),
        .result_word     (result_word),
        .result_index    (result_index),
        .last            (last),
        .result_all_zero (result_all_zero),
        .low_order_input (low_order_input)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(64'd400_000_000);
        $display("Verification failed");
        $finish;
    end

    // ---------------- field arithmetic mod 2^255-19 ----------------
    function automatic logic [255:0] fe_mul(input logic [255:0] a, input logic [255:0] b);
        logic [511:0] prod;
        prod = {256'd0, a} * {256'd0, b};
        return 256'(prod % {256'd0, P25519});
    endfunction

    function automatic logic [255:0] fe_add(input logic [255:0] a, input logic [255:0] b);
        logic [256:0] s;
        s = {1'b0, a} + {1'b0, b};
        return 256'(s % {1'b0, P25519});
    endfunction

    function automatic logic [255:0] fe_sub(input logic [255:0] a, input logic [255:0] b);
        return fe_add(a, P25519 - b);
    endfunction

    // z^(p-2); zero maps to zero
    function automatic logic [255:0] inv_mod_p(input logic [255:0] z);
        logic [255:0] acc;
        logic [255:0] e;
        acc = 256'd1;
        e = P25519 - 256'd2;
        for (int i = 254; i >= 0; i--)
        begin
            acc = fe_mul(acc, acc);
            if (e[i])
                acc = fe_mul(acc, z);
        end
        return acc;
    endfunction

    function automatic logic [255:0] x25519_ladder(input logic [255:0] scalar,
                                                  input logic [255:0] u_raw);
        logic [255:0] k, x1, x2, z2, x3, z3, tmp;
        logic [255:0] a, aa, b, bb, e, c, d, da, cb;
        logic         swap;
        k = scalar;
        k[2:0] = 3'b000;
        k[255] = 1'b0;
        k[254] = 1'b1;
        x1 = u_raw;
        x1[255] = 1'b0;
        x1 = x1 % P25519;
        x2 = 256'd1; z2 = 256'd0; x3 = x1; z3 = 256'd1;
        swap = 1'b0;
        for (int i = 254; i >= 0; i--)
        begin
            swap = swap ^ k[i];
            if (swap)
            begin
                tmp = x2; x2 = x3; x3 = tmp;
                tmp = z2; z2 = z3; z3 = tmp;
            end
            swap = k[i];
            a  = fe_add(x2, z2);
            aa = fe_mul(a, a);
            b  = fe_sub(x2, z2);
            bb = fe_mul(b, b);
            e  = fe_sub(aa, bb);
            c  = fe_add(x3, z3);
            d  = fe_sub(x3, z3);
            da = fe_mul(d, a);
            cb = fe_mul(c, b);
            tmp = fe_add(da, cb);
            x3 = fe_mul(tmp, tmp);
            tmp = fe_sub(da, cb);
            z3 = fe_mul(x1, fe_mul(tmp, tmp));
            x2 = fe_mul(aa, bb);
            z2 = fe_mul(e, fe_add(fe_mul(e, {239'd0, A24_VAL}), bb));
        end
        if (swap)
        begin
            x2 = x3;
            z2 = z3;
        end
        return fe_mul(x2, inv_mod_p(z2));
    endfunction

    // Update the stores and queue the four result words a compute produces
    task automatic predict_transaction(input logic [1:0] k_kind, input logic [1:0] idx,
                                       input logic [WORD_W-1:0] w, input logic base);
        logic [255:0] u;
        logic [255:0] scalar;
        logic [255:0] res;
        logic         low;
        ucoord_word_t r;
        if (k_kind == KIND_SCALAR)
            scalar_words[idx] = w;
        else if (k_kind == KIND_POINT)
            point_words[idx] = w;
        else if (k_kind == KIND_COMPUTE)
        begin
            scalar = {scalar_words[3], scalar_words[2], scalar_words[1], scalar_words[0]};
            u = base ? 256'd9 : {point_words[3], point_words[2], point_words[1], point_words[0]};
            low = 1'b0;
            if (!base)
                for (int i = 0; i < 7; i++)
                    if (u == LOW_ORDER_PTS[i])
                        low = 1'b1;
            res = x25519_ladder(scalar, u);
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                r.word = res[64*i +: 64];
                r.index = 2'(i);
                r.last = (i == NUM_WORDS - 1);
                r.all_zero = (res == 256'd0);
                r.low_order = low;
                expected_words.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] exp);
        $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, exp);
        errors++;
    endtask

    always @(posedge clk)
    begin
        ucoord_word_t exp_r;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected result", result_word, '0);
            else
            begin
                exp_r = expected_words.pop_front();
                if (result_word !== exp_r.word)
                    report_mismatch("result_word", result_word, exp_r.word);
                if (result_index !== exp_r.index)
                    report_mismatch("result_index", 64'(result_index), 64'(exp_r.index));
                if (last !== exp_r.last)
                    report_mismatch("last", 64'(last), 64'(exp_r.last));
                if (result_all_zero !== exp_r.all_zero)
                    report_mismatch("result_all_zero", 64'(result_all_zero),
                                    64'(exp_r.all_zero));
                if (low_order_input !== exp_r.low_order)
                    report_mismatch("low_order_input", 64'(low_order_input),
                                    64'(exp_r.low_order));
            end
        end
    end

    // One transaction; gap < 0 draws a random idle count
    task automatic send_item(input logic [1:0] k_kind, input logic [1:0] idx,
                             input logic [WORD_W-1:0] w, input logic base, input int gap);
        int  n;
        bit  done;
        n = (gap < 0) ? $urandom_range(0, 18) : gap;
        repeat (n)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        kind = k_kind;
        word_index = idx;
        word = w;
        use_base_point = base;
        done = 0;
        while (!done)
        begin
            @(posedge clk);
            if (!busy)
            begin
                done = 1;
                predict_transaction(k_kind, idx, w, base);
            end
            @(negedge clk);
        end
        start = 1'b0;
    endtask

    task automatic load_scalar(input logic [255:0] s, input int gap);
        for (int i = 0; i < 4; i++)
            send_item(KIND_SCALAR, 2'(i), s[64*i +: 64], 1'($urandom_range(0, 1)), gap);
    endtask

    task automatic load_point(input logic [255:0] u, input int gap);
        for (int i = 0; i < 4; i++)
            send_item(KIND_POINT, 2'(i), u[64*i +: 64], 1'($urandom_range(0, 1)), gap);
    endtask

    task automatic drain;
        wait (expected_words.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Extremes: all-ones scalar on the base point, back to back
    task automatic test_base_point;
        load_scalar({256{1'b1}}, 0);
        load_point(256'd0, 0);
        send_item(KIND_COMPUTE, 2'd0, '0, 1'b1, 0);
        drain();
    endtask

    // Zero point gives a zero result; order-8 point flagged low order
    task automatic test_low_order_points;
        load_scalar(256'd0, -1);
        send_item(KIND_COMPUTE, 2'd3, '1, 1'b0, -1);
        load_point(LOW_ORDER_PTS[2], -1);
        send_item(KIND_UNUSED, 2'd1, rand_word(), 1'b1, -1);
        send_item(KIND_COMPUTE, 2'd0, '0, 1'b0, -1);
        drain();
    endtask

    // Bit 255 set and value above p: ignored bit, no low-order flag
    task automatic test_point_decoding;
        load_point({256{1'b1}}, -1);
        send_item(KIND_COMPUTE, 2'd1, rand_word(), 1'b0, -1);
        drain();
    endtask

    task automatic test_random;
        logic [255:0] pt;
        int           gap;
        int           r;
        for (int round = 0; round < 5; round++)
        begin
            gap = (round == 2) ? 0 : -1;
            for (int i = 0; i < 15; i++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_item(KIND_UNUSED, 2'($urandom()), rand_word(), 1'($urandom()), gap);
                else
                    send_item((r < 10) ? KIND_SCALAR : KIND_POINT, 2'($urandom()),
                              (r == 5) ? '1 : (r == 6) ? '0 : rand_word(),
                              1'($urandom()), gap);
            end
            if (round == 3)
            begin
                pt = LOW_ORDER_PTS[$urandom_range(0, 6)];
                load_point(pt, gap);
            end
            send_item(KIND_COMPUTE, 2'($urandom()), rand_word(), 1'(round == 4), gap);
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_SCALAR;
        word_index = 2'd0;
        word = '0;
        use_base_point = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_base_point();
        test_low_order_points();
        test_point_decoding();
        test_random();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
